@@ rtl/slsr_pkg.sv @@
// ----------------------------------------------------------------------------
// slsr_pkg
// Types and constants shared by the literal substring replace block.
// ----------------------------------------------------------------------------
package slsr_pkg;

    localparam int SLOTS = 16;
    localparam int CNT_W = 5;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_PAT_LEN = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAT_LO  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAT_HI  = 3'd2;
    localparam logic [IDX_W-1:0] REG_REP_LEN = 3'd3;
    localparam logic [IDX_W-1:0] REG_REP_LO  = 3'd4;
    localparam logic [IDX_W-1:0] REG_REP_HI  = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_empty;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_empty;
        logic       out_last;
    } t_out_beat;

    // Control for the cell row.
    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } t_cell_ctl;

endpackage

@@ rtl/stream_literal_substring_replace.sv @@
// ----------------------------------------------------------------------------
// stream_literal_substring_replace
// Replaces every leftmost non-overlapping occurrence of a literal pattern
// in a byte stream with a replacement string, using a row of byte cells.
// ----------------------------------------------------------------------------
// The input stalls while the block is busy, so each byte is handled fully
// before the next one is taken; output stalls hold the flush, replacement
// and end-of-string beats.
// Reset clears the pending count, control state and all configuration.
module stream_literal_substring_replace
    import slsr_pkg::*;
#(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_beat         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_beat        o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [63:0]      i_cfg_data
);
    localparam int PCAP = (MAX_PATTERN < SLOTS) ? MAX_PATTERN : SLOTS;
    localparam int RCAP = (MAX_REPLACEMENT < SLOTS) ? MAX_REPLACEMENT : SLOTS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_FLUSH, ST_REPL, ST_END, ST_OUT
    } t_state;

    t_state      r_state, r_ret;
    logic [4:0]  r_pat_len, r_rep_len;
    logic [63:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [CNT_W-1:0] r_count, r_ri;
    logic        r_last, r_emitted;
    t_out_beat   r_out;
    t_in_beat    r_in;

    logic [4:0]  plen, rlen;
    logic [127:0] pat_all, rep_all;
    logic [7:0]  cell_byte [SLOTS];
    logic        cell_eq [SLOTS];
    logic        cell_sel [SLOTS];
    t_cell_ctl   ctl;
    logic        prefix;
    logic [7:0]  rep_byte;

    assign plen = (r_pat_len > 5'(PCAP)) ? 5'(PCAP) : r_pat_len;
    assign rlen = (r_rep_len > 5'(RCAP)) ? 5'(RCAP) : r_rep_len;
    assign pat_all = {r_pat_hi, r_pat_lo};
    assign rep_all = {r_rep_hi, r_rep_lo};
    assign rep_byte = rep_all[{r_ri[3:0], 3'b000} +: 8];

    always_comb begin
        prefix = (r_count <= plen);
        for (int k = 0; k < SLOTS; k++) begin
            if (5'(k) < r_count && !cell_eq[k]) begin
                prefix = 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            assign cell_sel[g] = (r_count[3:0] == 4'(g));
            slsr_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_sel       (cell_sel[g]),
                .i_load_byte (r_in.in_byte),
                .i_next_byte ((g == SLOTS - 1) ? 8'd0 : cell_byte[(g + 1) % SLOTS]),
                .i_pat_byte  (pat_all[g*8 +: 8]),
                .o_byte      (cell_byte[g]),
                .o_eq        (cell_eq[g])
            );
        end
    endgenerate

    logic out_free;
    logic out_load;
    assign out_free    = !o_valid || !i_stall;
    assign out_load    = out_free && ((r_state == ST_FLUSH) ||
                         (r_state == ST_REPL && r_ri != rlen) ||
                         (r_state == ST_END && r_last && r_count == '0 && !r_emitted));
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_data      = r_out;

    always_comb begin
        ctl = '0;
        if (r_state == ST_FLUSH && out_free) begin
            ctl.shift = 1'b1;
        end
        if (r_state == ST_CHECK && r_ret == ST_IDLE) begin
            ctl.load = 1'b1;
        end
    end

    logic o_valid_r;
    assign o_valid = o_valid_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret <= ST_IDLE;
            r_count <= '0;
            r_pat_len <= '0;
            r_rep_len <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_rep_lo <= '0;
            r_rep_hi <= '0;
            o_valid_r <= 1'b0;
            r_emitted <= 1'b0;
            r_last <= 1'b0;
            r_ri <= '0;
        end else begin
            if (o_valid_r && !i_stall && !out_load) begin
                o_valid_r <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAT_LEN: r_pat_len <= i_cfg_data[4:0];
                    REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                    REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                    REG_REP_LEN: r_rep_len <= i_cfg_data[4:0];
                    REG_REP_LO:  r_rep_lo  <= i_cfg_data;
                    REG_REP_HI:  r_rep_hi  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                        r_last <= i_data.in_last;
                        r_emitted <= 1'b0;
                        if (i_data.in_empty) begin
                            r_state <= i_data.in_last ? ST_END : ST_IDLE;
                        end else if (r_count == CNT_W'(SLOTS)) begin
                            // Full row: the oldest byte leaves before the load.
                            r_ret <= ST_CHECK;
                            r_state <= ST_FLUSH;
                        end else begin
                            r_ret <= ST_IDLE;
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_ret != ST_IDLE) begin
                        // Returning from the forced pop: arm the load into the freed slot.
                        r_ret <= ST_IDLE;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_ret <= ST_OUT;
                        r_state <= ST_CHECK;
                    end
                    if (r_ret == ST_OUT) begin
                        if (prefix) begin
                            if (plen != 0 && r_count == plen) begin
                                r_count <= '0;
                                r_ri <= '0;
                                r_state <= ST_REPL;
                            end else begin
                                r_state <= ST_END;
                            end
                        end else begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        o_valid_r <= 1'b1;
                        r_out <= '{out_byte: cell_byte[0], out_empty: 1'b0,
                                   out_last: r_last && r_count == 5'd1 && r_ret != ST_CHECK};
                        r_emitted <= 1'b1;
                        r_count <= r_count - 1'b1;
                        if (r_ret == ST_CHECK) begin
                            r_state <= ST_CHECK;
                        end else begin
                            r_state <= ST_END;
                        end
                    end
                end
                ST_REPL: begin
                    if (r_ri == rlen) begin
                        r_state <= ST_END;
                    end else if (out_free) begin
                        o_valid_r <= 1'b1;
                        r_out <= '{out_byte: rep_byte, out_empty: 1'b0,
                                   out_last: r_last && (r_ri + 1'b1 == rlen)};
                        r_emitted <= 1'b1;
                        r_ri <= r_ri + 1'b1;
                    end
                end
                ST_END: begin
                    if (r_last && r_count != 0) begin
                        r_ret <= ST_FLUSH;
                        r_state <= ST_FLUSH;
                    end else if (r_last && !r_emitted) begin
                        if (out_free) begin
                            o_valid_r <= 1'b1;
                            r_out <= '{out_byte: 8'd0, out_empty: 1'b1, out_last: 1'b1};
                            r_state <= ST_IDLE;
                        end
                    end else if (!r_last && r_count != 0 && !prefix) begin
                        r_ret <= ST_OUT;
                        r_state <= ST_FLUSH;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("pending count above slot count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_empty |-> o_data.out_byte == 8'd0)
        else $error("empty beat carries a byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_stall)
        else $error("input open while busy");
endmodule

@@ rtl/slsr_cell.sv @@
// ----------------------------------------------------------------------------
// slsr_cell
// One pending byte slot: holds or loads a byte, compares it with its pattern
// byte, and takes its neighbor's byte when the row shifts toward the head.
// ----------------------------------------------------------------------------
module slsr_cell
    import slsr_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_sel,
    input  logic [7:0] i_load_byte,
    input  logic [7:0] i_next_byte,
    input  logic [7:0] i_pat_byte,
    output logic [7:0] o_byte,
    output logic       o_eq
);
    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_next_byte;
        end else if (i_ctl.load && i_sel) begin
            n_byte = i_load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_pat_byte);
endmodule
